### rtl/core/tfra_pkg.sv
// Shared types and constants for the trace frame ring allocator.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tfra_pkg;

  // Width of the input length field in bytes, and of one result field.
  localparam int BYTES_W = 15;
  localparam int FIELD_W = 12;

  // A frame length in units: header plus up to 4096 payload units.
  localparam int LEN_W = 13;

  // Bytes per store unit, as a shift.
  localparam int UNIT_SHIFT = 3;

  // Saturation point of the dropped-frame count.
  localparam logic [FIELD_W-1:0] DROP_MAX = '1;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             too_large;
  } job_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_CHECK,
    BS_DROP,
    BS_FIN
  } back_state_t;

endpackage

`default_nettype wire

### rtl/core/tfra_front.sv
// Front stage of the allocator: accepts a request and computes its frame length.
// Depends on tfra_pkg for the job type and field widths.
`timescale 1ns / 1ps
`default_nettype none

module tfra_front #(
  parameter int STORE_UNITS  = 4096,
  parameter int HEADER_UNITS = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [tfra_pkg::BYTES_W-1:0] in_payload_bytes,
  output logic                         job_valid,
  input  wire                          job_ready,
  output tfra_pkg::job_t               job
);

  localparam int CW = (tfra_pkg::LEN_W > 18) ? tfra_pkg::LEN_W : 18;
  localparam logic [CW-1:0] LEN_LIMIT = CW'(STORE_UNITS - 1);
  localparam logic [tfra_pkg::LEN_W-1:0] HDR = tfra_pkg::LEN_W'(HEADER_UNITS);

  logic                        valid_r, valid_nxt;
  tfra_pkg::job_t              job_r, job_nxt;
  logic [tfra_pkg::BYTES_W:0]  bytes_round;
  logic [tfra_pkg::LEN_W-1:0]  frame_len;

  // Payload rounded up to whole units, plus the header.
  always_comb begin
    bytes_round = {1'b0, in_payload_bytes} + (tfra_pkg::BYTES_W + 1)'(7);
    frame_len   = tfra_pkg::LEN_W'(bytes_round >> tfra_pkg::UNIT_SHIFT) + HDR;
  end

  assign in_ready  = !valid_r || job_ready;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_comb begin
    valid_nxt = valid_r && !job_ready;
    job_nxt   = job_r;
    if (in_valid && in_ready) begin
      valid_nxt         = 1'b1;
      job_nxt.len       = frame_len;
      job_nxt.too_large = CW'(frame_len) > LEN_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    job_r <= job_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/tfra_queue.sv
// Two-entry queue that decouples the front stage from the allocation sequencer.
// Depends on tfra_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module tfra_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push_valid,
  output logic            push_ready,
  input  tfra_pkg::job_t  push_job,
  output logic            pop_valid,
  input  wire             pop_ready,
  output tfra_pkg::job_t  pop_job
);

  tfra_pkg::job_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tfra_back.sv
// Allocation sequencer: owns the ring pointers and the frame length memory.
// Discards oldest frames, writes pad frames and records new frames; depends on tfra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfra_back #(
  parameter int STORE_UNITS = 4096
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          job_valid,
  output logic                         job_ready,
  input  tfra_pkg::job_t               job,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [tfra_pkg::FIELD_W-1:0] out_frame_start,
  output logic [tfra_pkg::FIELD_W-1:0] out_read_pointer,
  output logic [tfra_pkg::FIELD_W-1:0] out_write_pointer,
  output logic [tfra_pkg::FIELD_W-1:0] out_used_units,
  output logic [tfra_pkg::FIELD_W-1:0] out_frames_dropped,
  output logic                         out_pad_written,
  output logic                         out_too_large
);

  localparam int PW = $clog2(STORE_UNITS);
  localparam int FW = tfra_pkg::FIELD_W;
  localparam logic [PW:0] SIZE = (PW + 1)'(STORE_UNITS);

  tfra_pkg::back_state_t state_r, state_nxt;

  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic          tl_r, tl_nxt;
  logic [PW-1:0] start_r, start_nxt;
  logic [FW-1:0] drop_r, drop_nxt;
  logic          pad_r, pad_nxt;

  logic          ov_r, ov_nxt;
  logic [FW-1:0] o_start_r, o_start_nxt;
  logic [FW-1:0] o_rp_r, o_rp_nxt;
  logic [FW-1:0] o_wp_r, o_wp_nxt;
  logic [FW-1:0] o_used_r, o_used_nxt;
  logic [FW-1:0] o_drop_r, o_drop_nxt;
  logic          o_pad_r, o_pad_nxt;
  logic          o_tl_r, o_tl_nxt;

  logic [PW-1:0] len_mem [STORE_UNITS];
  logic [PW-1:0] rdata_r;
  logic          mem_we;
  logic [PW-1:0] mem_wd;

  logic [PW:0]   free_units;
  logic [PW:0]   tail_units;
  logic [PW:0]   wp_sum;
  logic [PW:0]   rp_sum;
  logic [PW:0]   used_units;

  // Ring arithmetic; every pointer stays below the store size.
  always_comb begin
    if (rp_r > wp_r) begin
      free_units = {1'b0, rp_r} - {1'b0, wp_r} - (PW + 1)'(1);
    end else begin
      free_units = {1'b0, rp_r} + SIZE - {1'b0, wp_r} - (PW + 1)'(1);
    end
    tail_units = SIZE - {1'b0, wp_r};
    wp_sum     = {1'b0, wp_r} + {1'b0, len_r};
    rp_sum     = {1'b0, rp_r} + {1'b0, rdata_r};
    if (wp_r >= rp_r) begin
      used_units = {1'b0, wp_r} - {1'b0, rp_r};
    end else begin
      used_units = {1'b0, wp_r} + SIZE - {1'b0, rp_r};
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rp_nxt      = rp_r;
    wp_nxt      = wp_r;
    len_nxt     = len_r;
    tl_nxt      = tl_r;
    start_nxt   = start_r;
    drop_nxt    = drop_r;
    pad_nxt     = pad_r;
    job_ready   = 1'b0;
    mem_we      = 1'b0;
    mem_wd      = len_r;
    ov_nxt      = ov_r && !out_ready;
    o_start_nxt = o_start_r;
    o_rp_nxt    = o_rp_r;
    o_wp_nxt    = o_wp_r;
    o_used_nxt  = o_used_r;
    o_drop_nxt  = o_drop_r;
    o_pad_nxt   = o_pad_r;
    o_tl_nxt    = o_tl_r;

    case (state_r)
      tfra_pkg::BS_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          len_nxt   = PW'(job.len);
          tl_nxt    = job.too_large;
          start_nxt = wp_r;
          drop_nxt  = '0;
          pad_nxt   = 1'b0;
          state_nxt = job.too_large ? tfra_pkg::BS_FIN : tfra_pkg::BS_CHECK;
        end
      end
      tfra_pkg::BS_CHECK: begin
        if (free_units < {1'b0, len_r}) begin
          // Not enough room: the oldest frame's length is read this cycle.
          state_nxt = tfra_pkg::BS_DROP;
        end else if (tail_units < {1'b0, len_r}) begin
          // Tail too short: record a pad frame and wrap to the start.
          mem_we  = 1'b1;
          mem_wd  = PW'(tail_units);
          wp_nxt  = '0;
          pad_nxt = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_wd    = len_r;
          start_nxt = wp_r;
          wp_nxt    = (wp_sum == SIZE) ? '0 : PW'(wp_sum);
          state_nxt = tfra_pkg::BS_FIN;
        end
      end
      tfra_pkg::BS_DROP: begin
        if (rdata_r == '0) begin
          rp_nxt = wp_r;
        end else if (rp_sum >= SIZE) begin
          rp_nxt = PW'(rp_sum - SIZE);
        end else begin
          rp_nxt = PW'(rp_sum);
        end
        if (drop_r != tfra_pkg::DROP_MAX) begin
          drop_nxt = drop_r + FW'(1);
        end
        state_nxt = tfra_pkg::BS_CHECK;
      end
      tfra_pkg::BS_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt      = 1'b1;
          o_start_nxt = FW'(start_r);
          o_rp_nxt    = FW'(rp_r);
          o_wp_nxt    = FW'(wp_r);
          o_used_nxt  = FW'(used_units);
          o_drop_nxt  = drop_r;
          o_pad_nxt   = pad_r;
          o_tl_nxt    = tl_r;
          state_nxt   = tfra_pkg::BS_IDLE;
        end
      end
      default: begin
        state_nxt = tfra_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfra_pkg::BS_IDLE;
      rp_r    <= '0;
      wp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      ov_r    <= ov_nxt;
    end
    len_r     <= len_nxt;
    tl_r      <= tl_nxt;
    start_r   <= start_nxt;
    drop_r    <= drop_nxt;
    pad_r     <= pad_nxt;
    o_start_r <= o_start_nxt;
    o_rp_r    <= o_rp_nxt;
    o_wp_r    <= o_wp_nxt;
    o_used_r  <= o_used_nxt;
    o_drop_r  <= o_drop_nxt;
    o_pad_r   <= o_pad_nxt;
    o_tl_r    <= o_tl_nxt;
  end

  // Length memory: one write port at the write pointer, one registered read at the read pointer.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      len_mem[wp_r] <= mem_wd;
    end
    rdata_r <= len_mem[rp_r];
  end

  assign out_valid          = ov_r;
  assign out_frame_start    = o_start_r;
  assign out_read_pointer   = o_rp_r;
  assign out_write_pointer  = o_wp_r;
  assign out_used_units     = o_used_r;
  assign out_frames_dropped = o_drop_r;
  assign out_pad_written    = o_pad_r;
  assign out_too_large      = o_tl_r;

endmodule

`default_nettype wire

### rtl/core/trace_frame_ring_allocator.sv
// Trace frame ring allocator: top level joining the front stage, queue and sequencer.
// Depends on tfra_pkg, tfra_front, tfra_queue and tfra_back.
//
// Usage: each input transaction on the in_ channel carries a payload length in bytes. The
// block sizes the frame (header units plus the payload rounded up to 8-byte units), makes
// room in the circular store by discarding the oldest frames, pads the tail and wraps when
// the frame would cross the end of the store, and records the frame length at its start.
// Each request yields exactly one output transaction on the out_ channel with the frame
// start, both pointers, the occupancy, the count of discarded frames (pads included,
// saturating), a pad flag, and a too-large flag for frames that can never fit; such a
// request leaves all state untouched.
// With nothing to discard, an accepted request passes the front register, then the queue
// while the sequencer takes the job, then a check of the free space that records the frame,
// and then the load of the output register. Each discarded frame adds a registered read of
// the length memory at the read pointer followed by the pointer update, and a pad frame adds
// a further free-space check.
// The sequencer takes a new request only after it has loaded the output register for the
// last one, so the sequencer sets the rate.
// Reset clears both pointers and empties the pipeline; the length memory is not cleared,
// since every entry it is asked for has been written first.
// Stalls: the output register holds a finished result while out_ready is low; the front
// register and the two-entry queue keep accepting requests until they fill up.
`timescale 1ns / 1ps
`default_nettype none

module trace_frame_ring_allocator #(
  parameter int STORE_UNITS  = 4096,
  parameter int HEADER_UNITS = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [tfra_pkg::BYTES_W-1:0] in_payload_bytes,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [tfra_pkg::FIELD_W-1:0] out_frame_start,
  output logic [tfra_pkg::FIELD_W-1:0] out_read_pointer,
  output logic [tfra_pkg::FIELD_W-1:0] out_write_pointer,
  output logic [tfra_pkg::FIELD_W-1:0] out_used_units,
  output logic [tfra_pkg::FIELD_W-1:0] out_frames_dropped,
  output logic                         out_pad_written,
  output logic                         out_too_large
);

  // Classified requests leaving the front stage.
  logic           fr_valid;
  logic           fr_ready;
  tfra_pkg::job_t fr_job;

  // Requests queued for the sequencer.
  logic           q_valid;
  logic           q_ready;
  tfra_pkg::job_t q_job;

  tfra_front #(
    .STORE_UNITS (STORE_UNITS),
    .HEADER_UNITS(HEADER_UNITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_bytes(in_payload_bytes),
    .job_valid       (fr_valid),
    .job_ready       (fr_ready),
    .job             (fr_job)
  );

  tfra_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fr_valid),
    .push_ready(fr_ready),
    .push_job  (fr_job),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_job   (q_job)
  );

  // The sequencer owns the pointers, the length memory and the output register.
  tfra_back #(
    .STORE_UNITS(STORE_UNITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (q_valid),
    .job_ready         (q_ready),
    .job               (q_job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_start   (out_frame_start),
    .out_read_pointer  (out_read_pointer),
    .out_write_pointer (out_write_pointer),
    .out_used_units    (out_used_units),
    .out_frames_dropped(out_frames_dropped),
    .out_pad_written   (out_pad_written),
    .out_too_large     (out_too_large)
  );

endmodule

`default_nettype wire
